// ----- rtl/bsfc_pkg.sv -----
// Package for the byte-stuffing frame codec: payload structs, job descriptor
// and framing byte constants. No dependencies.
package bsfc_pkg;

   localparam int MAX_RESULTS    = 4;
   localparam int SLOT_IDX_W     = $clog2(MAX_RESULTS);
   localparam int SLOT_CNT_W     = $clog2(MAX_RESULTS + 1);
   localparam int JOB_DEPTH_DEF  = 4;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [7:0] START_BYTE = 8'hF1;
   localparam logic [7:0] END_BYTE   = 8'hFF;
   localparam logic [7:0] ESC_BYTE   = 8'hF0;
   localparam logic [3:0] HIGH_NIB   = 4'hF;

   localparam logic [0:0] REG_MODE = 1'b0;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_ESC = 2'd1,
      ST_OUTSIDE = 2'd2,
      ST_RESTART = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       frame_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       frame_end;
      logic [1:0] status;
      logic       run_last;
   } rsp_payload_type;

   // one result of a job, run_last added by the back end
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       frame_end;
      logic [1:0] status;
   } slot_type;

   typedef struct packed {
      slot_type [MAX_RESULTS-1:0] slots;
      logic [SLOT_IDX_W-1:0]      last_idx;
   } job_type;

   typedef struct packed {
      logic mode;
      logic clear;
   } ctrl_type;

endpackage

// ----- rtl/bsfc_front.sv -----
// Front end: classifies each request byte, updates framing state and builds
// a job of up to four results. Depends on bsfc_pkg.
module bsfc_front import bsfc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ctrl_type        ctrl,
   input  logic            accept,
   input  req_payload_type req,
   output logic            job_push,
   output job_type         job
);

   logic in_frame_ff, in_frame_in;
   logic esc_ff, esc_in;

   function automatic slot_type mk(input logic [7:0] b, input logic v,
                                   input logic e, input status_type s);
      slot_type r;
      r.out_byte   = v ? b : 8'h00;
      r.byte_valid = v;
      r.frame_end  = e;
      r.status     = s;
      return r;
   endfunction

   always_comb begin
      logic [SLOT_CNT_W-1:0] n;
      logic [7:0] b;
      logic       plain;
      n           = '0;
      b           = req.in_byte;
      plain       = 1'b1;
      in_frame_in = in_frame_ff;
      esc_in      = esc_ff;
      job.slots   = '0;
      if (!ctrl.mode) begin
         if (!in_frame_ff) begin
            job.slots[n[SLOT_IDX_W-1:0]] = mk(START_BYTE, 1'b1, 1'b0, ST_OK);
            n = n + 1'b1;
            in_frame_in = 1'b1;
         end
         if (b[7:4] == HIGH_NIB) begin
            job.slots[n[SLOT_IDX_W-1:0]] = mk(ESC_BYTE, 1'b1, 1'b0, ST_OK);
            n = n + 1'b1;
            job.slots[n[SLOT_IDX_W-1:0]] = mk({4'h0, b[3:0]}, 1'b1, 1'b0, ST_OK);
            n = n + 1'b1;
         end else begin
            job.slots[n[SLOT_IDX_W-1:0]] = mk(b, 1'b1, 1'b0, ST_OK);
            n = n + 1'b1;
         end
         if (req.frame_last) begin
            job.slots[n[SLOT_IDX_W-1:0]] = mk(END_BYTE, 1'b1, 1'b1, ST_OK);
            n = n + 1'b1;
            in_frame_in = 1'b0;
         end
      end else begin
         if (esc_ff) begin
            esc_in = 1'b0;
            if (b[7:4] == 4'h0) begin
               job.slots[n[SLOT_IDX_W-1:0]] = mk(ESC_BYTE | b, 1'b1, 1'b0, ST_OK);
               n = n + 1'b1;
               plain = 1'b0;
            end else begin
               job.slots[n[SLOT_IDX_W-1:0]] = mk(8'h00, 1'b0, 1'b0, ST_BAD_ESC);
               n = n + 1'b1;
            end
         end
         if (plain) begin
            if (b == START_BYTE) begin
               if (in_frame_ff) begin
                  job.slots[n[SLOT_IDX_W-1:0]] = mk(8'h00, 1'b0, 1'b0, ST_RESTART);
                  n = n + 1'b1;
               end
               in_frame_in = 1'b1;
            end else if (!in_frame_ff) begin
               job.slots[n[SLOT_IDX_W-1:0]] = mk(8'h00, 1'b0, 1'b0, ST_OUTSIDE);
               n = n + 1'b1;
            end else if (b == END_BYTE) begin
               job.slots[n[SLOT_IDX_W-1:0]] = mk(8'h00, 1'b0, 1'b1, ST_OK);
               n = n + 1'b1;
               in_frame_in = 1'b0;
            end else if (b == ESC_BYTE) begin
               esc_in = 1'b1;
            end else if (b[7:4] == HIGH_NIB) begin
               // stray high byte, frame stays open
               job.slots[n[SLOT_IDX_W-1:0]] = mk(8'h00, 1'b0, 1'b0, ST_BAD_ESC);
               n = n + 1'b1;
            end else begin
               job.slots[n[SLOT_IDX_W-1:0]] = mk(b, 1'b1, 1'b0, ST_OK);
               n = n + 1'b1;
            end
         end
      end
      job.last_idx = SLOT_IDX_W'(n - 1'b1);
      job_push     = accept && (n != '0);
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         in_frame_ff <= 1'b0;
         esc_ff      <= 1'b0;
      end else if (accept) begin
         in_frame_ff <= in_frame_in;
         esc_ff      <= esc_in;
      end
   end

endmodule

// ----- rtl/bsfc_job_fifo.sv -----
// Short job queue between front and back end, register based.
// Depends on bsfc_pkg.
module bsfc_job_fifo import bsfc_pkg::*; #(
   parameter int DEPTH = JOB_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type wr_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type rd_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_job  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entries_ff[wr_ptr_ff] <= wr_job;
   end

endmodule

// ----- rtl/bsfc_back.sv -----
// Back end: walks the slots of the head job into the response register,
// one result per cycle while it is empty or popped. Depends on bsfc_pkg.
module bsfc_back import bsfc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            job_empty,
   input  job_type         job,
   output logic            job_pop,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output rsp_payload_type rsp
);

   logic [SLOT_IDX_W-1:0] idx_ff, idx_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_payload_type       rsp_ff, rsp_in;
   logic                  emit, last_slot;
   slot_type              cur;

   assign cur       = job.slots[idx_ff];
   assign last_slot = (idx_ff == job.last_idx);
   // output register refills in the cycle it is popped
   assign emit      = !job_empty && (!out_valid_ff || rsp_pop);
   assign job_pop   = emit && last_slot;
   assign rsp_empty = !out_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_pop && out_valid_ff)
         out_valid_in = 1'b0;
      if (emit) begin
         out_valid_in      = 1'b1;
         rsp_in.out_byte   = cur.out_byte;
         rsp_in.byte_valid = cur.byte_valid;
         rsp_in.frame_end  = cur.frame_end;
         rsp_in.status     = cur.status;
         rsp_in.run_last   = last_slot;
         idx_in            = last_slot ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

// ----- rtl/byte_stuff_frame_codec_unit.sv -----
// Top level of the byte-stuffing frame codec: mode register on the csr port,
// front end, job queue and back end. Depends on bsfc_pkg and the bsfc modules.
//
// Usage: requests (in_byte, frame_last) are pushed while req_full is low.
// Mode 0 frames raw data (start byte, nibble escapes, end byte on the byte
// marked last); mode 1 unframes line bytes and reports errors in status.
// Each request yields zero to four responses, read in order with rsp_pop
// while rsp_empty is low; run_last marks the last response of a request.
// A request passes through the job queue and then the response register.
// Throughput: one request per cycle while each gives one response and the
// receiver keeps popping; a request with several responses holds the back
// end for one slot each, so the sustained rate is set by the back end's
// one-slot-per-cycle walk, with the job queue (JOB_DEPTH entries) absorbing
// bursts of escape expansion. Requests that give no response (opening start
// byte, escape byte in decode) use only the front end.
// When the receiver stalls the response register holds, the queue fills and
// req_full rises. Reset clears mode to encode, the job queue, the response register and framing state.
// Writing the mode register also clears the framing state; write it only
// while no responses are outstanding.
module byte_stuff_frame_codec_unit import bsfc_pkg::*; #(
   parameter int JOB_DEPTH = JOB_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_payload_type       req_payload,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic     mode_ff;
   logic     csr_wr, mode_wr;
   ctrl_type ctrl;
   logic     accept, job_push, job_pop, job_empty;
   job_type  wr_job, rd_job;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign mode_wr    = csr_wr && (csr_paddr[CSR_ADDR_W-1:2] == REG_MODE);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_MODE) ?
                       {{(CSR_DATA_W-1){1'b0}}, mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset)
         mode_ff <= 1'b0;
      else if (mode_wr)
         mode_ff <= csr_pwdata[0];
   end

   assign ctrl.mode  = mode_ff;
   assign ctrl.clear = mode_wr;
   assign accept     = req_push && !req_full;

   bsfc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .accept   (accept),
      .req      (req_payload),
      .job_push (job_push),
      .job      (wr_job)
   );

   bsfc_job_fifo #(.DEPTH(JOB_DEPTH)) u_jobq (
      .clock  (clock),
      .reset  (reset),
      .push   (job_push),
      .wr_job (wr_job),
      .full   (req_full),
      .pop    (job_pop),
      .empty  (job_empty),
      .rd_job (rd_job)
   );

   bsfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (rd_job),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp_payload)
   );

endmodule

// ----- rtl/bsfc_checker.sv -----
// Port-level checks for the codec top level, bound to it below.
// Depends on bsfc_pkg.
module bsfc_checker import bsfc_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            rsp_empty,
   input logic            rsp_pop,
   input rsp_payload_type rsp_payload
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("responses visible right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_payload)))
      else $error("stalled response changed");

   a_no_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_payload.byte_valid) |-> (rsp_payload.out_byte == 8'h00))
      else $error("out_byte nonzero without byte_valid");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_payload.frame_end) |-> rsp_payload.run_last)
      else $error("frame end not the last response of its request");

   a_err_no_byte: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_payload.status != ST_OK)) |-> !rsp_payload.byte_valid)
      else $error("error response carries a byte");

endmodule

bind byte_stuff_frame_codec_unit bsfc_checker u_bsfc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_empty   (rsp_empty),
   .rsp_pop     (rsp_pop),
   .rsp_payload (rsp_payload)
);
